@@ src/idm_pkg.sv @@
// ----------------------------------------------------------------------------
// idm_pkg
// Shared types and constants of the interval deadline monitor.
// ----------------------------------------------------------------------------
package idm_pkg;

  // Ring of late-event ticks
  localparam int unsigned RingDepth = 64;
  localparam int unsigned RingAw    = $clog2(RingDepth);
  localparam int unsigned RcntW     = $clog2(RingDepth + 1);

  // Reporting constants
  localparam logic [31:0] WindowMs  = 32'd60000;
  localparam logic [9:0]  MsPerSec  = 10'd1000;

  // Milliseconds to seconds: x / 1000 == (x * SecRecip) >> SecShift for any 32-bit x
  localparam logic [31:0] SecRecip  = 32'h1062_4DD3;
  localparam int unsigned SecShift  = 38;

  // Iterative divider: one quotient bit per cycle
  localparam int unsigned DivSteps  = 32;
  localparam int unsigned DivCntW   = $clog2(DivSteps);

  // Queue between front and back
  localparam int unsigned FifoDepth = 4;
  localparam int unsigned FifoAw    = $clog2(FifoDepth);

  // Command codes of the input item
  localparam logic [1:0] CmdEvent = 2'd0;
  localparam logic [1:0] CmdSnap  = 2'd1;
  localparam logic [1:0] CmdClear = 2'd2;

  // Configuration register indexes
  localparam logic RegThreshold = 1'b0;
  localparam logic RegCyclesPerUs = 1'b1;

  localparam logic [9:0] CyclesPerUsReset = 10'd96;

  typedef enum logic [1:0] {
    OP_EVENT = 2'd0,
    OP_SNAP  = 2'd1,
    OP_CLEAR = 2'd2
  } op_e;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [31:0] cycle_stamp;
    logic [31:0] tick_ms;
  } in_data_t;

  typedef struct packed {
    logic [31:0] event_count;
    logic [31:0] late_count;
    logic [31:0] threshold_us;
    logic [31:0] max_interval_us;
    logic [22:0] first_late_sec;
    logic [22:0] last_late_sec;
    logic [6:0]  recent_late_count;
    logic        recent_capped;
  } out_data_t;

  // Classified transaction held in the queue
  typedef struct packed {
    op_e         op;
    logic [31:0] stamp;
    logic [31:0] tick;
  } q_item_t;

  // Push side of the queue
  typedef struct packed {
    logic    valid;
    q_item_t item;
  } q_push_t;

endpackage

@@ src/idm_div.sv @@
// ----------------------------------------------------------------------------
// idm_div
// Restoring divider, 32-bit dividend by 10-bit divisor, one bit per cycle.
// A zero divisor yields a zero quotient.
// ----------------------------------------------------------------------------
module idm_div
  import idm_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] num_i,
  input  logic [9:0]  den_i,
  output logic        done_o,
  output logic [31:0] quot_o
);

  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [DivCntW-1:0] cnt_q, cnt_d;
  logic [31:0]        dvd_q, dvd_d;
  logic [9:0]         rem_q, rem_d;
  logic [9:0]         den_q, den_d;
  logic               zero_q, zero_d;
  logic [10:0]        trial;
  logic               ge;

  // Shift in one dividend bit and try the subtraction
  assign trial = {rem_q, dvd_q[31]};
  assign ge    = trial >= {1'b0, den_q};

  always_comb begin
    busy_d = busy_q;
    done_d = done_q;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    den_d  = den_q;
    zero_d = zero_q;
    if (start_i) begin
      busy_d = 1'b1;
      done_d = 1'b0;
      cnt_d  = '0;
      dvd_d  = num_i;
      rem_d  = '0;
      den_d  = den_i;
      zero_d = (den_i == 10'd0);
    end else if (busy_q) begin
      dvd_d = {dvd_q[30:0], ge};
      rem_d = ge ? 10'(trial - {1'b0, den_q}) : trial[9:0];
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == DivCntW'(DivSteps - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q  <= dvd_d;
    rem_q  <= rem_d;
    den_q  <= den_d;
    zero_q <= zero_d;
  end

  assign done_o = done_q;
  assign quot_o = zero_q ? 32'd0 : dvd_q;

endmodule

@@ src/idm_fifo.sv @@
// ----------------------------------------------------------------------------
// idm_fifo
// Short queue of classified transactions between front and back.
// ----------------------------------------------------------------------------
module idm_fifo
  import idm_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  q_push_t push_i,
  output logic    full_o,
  input  logic    pop_i,
  output logic    empty_o,
  output q_item_t item_o
);

  q_item_t           mem_q [FifoDepth];
  logic [FifoAw-1:0] wptr_q, rptr_q;
  logic [FifoAw:0]   count_q;
  logic              do_push, do_pop;

  assign full_o  = (count_q == (FifoAw + 1)'(FifoDepth));
  assign empty_o = (count_q == '0);
  assign do_push = push_i.valid && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign item_o  = mem_q[rptr_q];

  // Store pushed transaction
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= push_i.item;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= (wptr_q == FifoAw'(FifoDepth - 1)) ? '0 : wptr_q + 1'b1;
      end
      if (do_pop) begin
        rptr_q <= (rptr_q == FifoAw'(FifoDepth - 1)) ? '0 : rptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

@@ src/idm_front.sv @@
// ----------------------------------------------------------------------------
// idm_front
// Input stage: accepts transactions, classifies the command and drops
// unused codes, then hands them to the queue.
// ----------------------------------------------------------------------------
module idm_front
  import idm_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  in_data_t in_data_i,
  output q_push_t  push_o,
  input  logic     full_i
);

  logic    st_vld_q, st_vld_d;
  q_item_t st_q;
  logic    accept;
  logic    push;
  logic    cmd_ok;
  op_e     op;

  assign push       = st_vld_q && !full_i;
  assign in_stall_o = st_vld_q && full_i;
  assign accept     = in_valid_i && !in_stall_o;

  // Classify the command code
  always_comb begin
    cmd_ok = 1'b1;
    op     = OP_EVENT;
    case (in_data_i.cmd)
      CmdEvent: op = OP_EVENT;
      CmdSnap:  op = OP_SNAP;
      CmdClear: op = OP_CLEAR;
      default:  cmd_ok = 1'b0;
    endcase
  end

  always_comb begin
    st_vld_d = st_vld_q;
    if (push) begin
      st_vld_d = 1'b0;
    end
    if (accept && cmd_ok) begin
      st_vld_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_vld_q <= 1'b0;
    end else begin
      st_vld_q <= st_vld_d;
    end
  end

  // Hold the classified transaction
  always_ff @(posedge clk_i) begin
    if (accept && cmd_ok) begin
      st_q <= '{op: op, stamp: in_data_i.cycle_stamp, tick: in_data_i.tick_ms};
    end
  end

  assign push_o = '{valid: st_vld_q, item: st_q};

endmodule

@@ src/idm_back.sv @@
// ----------------------------------------------------------------------------
// idm_back
// Execution side: interval statistics, late-event ring, snapshot walk with
// the unit conversions, and the output register.
// ----------------------------------------------------------------------------
module idm_back
  import idm_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        q_empty_i,
  input  q_item_t     q_item_i,
  output logic        q_pop_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_data_t   out_data_o
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_WALK  = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_FIN   = 4'b1000
  } state_e;

  state_e state_q, state_d;

  // Configuration
  logic [31:0] thr_q;
  logic [9:0]  cpu_q;

  // Statistics
  logic [31:0] prev_q, start_q, icnt_q, ocnt_q, max_q, first_q, last_q;
  logic        have_prev_q, have_first_q;
  logic [RingAw-1:0] head_q;

  // Ring storage with per-entry valid bits
  logic [31:0]          ring_mem [RingDepth];
  logic [RingDepth-1:0] ring_vld_q;
  logic [31:0]          rd_data_q;
  logic                 rd_vbit_q;
  logic                 rd_pend_q;
  logic [RingAw-1:0]    walk_q;
  logic [RcntW-1:0]     rcnt_q;
  logic [31:0]          now_q;

  // Output register
  logic      out_vld_q;
  out_data_t out_q;

  logic        pop;
  logic        is_event, is_snap, is_clear;
  logic [31:0] delta;
  logic        late;
  logic        ring_we;
  logic        rd_en;
  logic        hit;
  logic [31:0] age;
  logic        out_free;
  logic        out_load;
  logic [1:0]  div_done;
  logic [31:0] q_thr, q_max;
  logic [31:0] first_num_q, last_num_q;
  logic [22:0] first_sec_q, last_sec_q;
  logic [63:0] first_prod, last_prod;

  assign pop      = (state_q == ST_IDLE) && !q_empty_i;
  assign q_pop_o  = pop;
  assign is_event = pop && (q_item_i.op == OP_EVENT);
  assign is_snap  = pop && (q_item_i.op == OP_SNAP);
  assign is_clear = pop && (q_item_i.op == OP_CLEAR);

  // Interval and overrun test
  assign delta   = q_item_i.stamp - prev_q;
  assign late    = (thr_q != 32'd0) && (delta > thr_q);
  assign ring_we = is_event && have_prev_q && late;

  // Walk the ring one entry per cycle
  assign rd_en = (state_q == ST_WALK);
  assign age   = now_q - rd_data_q;
  assign hit   = rd_pend_q && rd_vbit_q && (rd_data_q != 32'd0) && (age < WindowMs);

  assign out_free = !out_vld_q || !out_stall_i;
  assign out_load = (state_q == ST_FIN) && (div_done == 2'b11) && out_free;

  // Sequence the snapshot
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (is_snap) state_d = ST_WALK;
      ST_WALK:  if (walk_q == RingAw'(RingDepth - 1)) state_d = ST_DRAIN;
      ST_DRAIN: state_d = ST_FIN;
      ST_FIN:   if (out_load) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // Take configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= '0;
      cpu_q <= CyclesPerUsReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegThreshold:   thr_q <= cfg_wdata_i;
        RegCyclesPerUs: cpu_q <= cfg_wdata_i[9:0];
        default:        thr_q <= thr_q;
      endcase
    end
  end

  // Update statistics on event and clear transactions
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q       <= '0;
      have_prev_q  <= 1'b0;
      start_q      <= '0;
      icnt_q       <= '0;
      ocnt_q       <= '0;
      max_q        <= '0;
      have_first_q <= 1'b0;
      first_q      <= '0;
      last_q       <= '0;
      head_q       <= '0;
      ring_vld_q   <= '0;
    end else if (is_event) begin
      prev_q      <= q_item_i.stamp;
      have_prev_q <= 1'b1;
      if (have_prev_q) begin
        icnt_q <= icnt_q + 32'd1;
        if (delta > max_q) begin
          max_q <= delta;
        end
        if (late) begin
          ocnt_q <= ocnt_q + 32'd1;
          if (!have_first_q) begin
            have_first_q <= 1'b1;
            first_q      <= q_item_i.tick;
          end
          last_q             <= q_item_i.tick;
          ring_vld_q[head_q] <= 1'b1;
          head_q <= (head_q == RingAw'(RingDepth - 1)) ? '0 : head_q + 1'b1;
        end
      end
    end else if (is_clear) begin
      start_q      <= q_item_i.tick;
      icnt_q       <= '0;
      ocnt_q       <= '0;
      max_q        <= '0;
      have_first_q <= 1'b0;
      first_q      <= '0;
      last_q       <= '0;
      head_q       <= '0;
      ring_vld_q   <= '0;
    end
  end

  // Ring memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (ring_we) begin
      ring_mem[head_q] <= q_item_i.tick;
    end
    if (rd_en) begin
      rd_data_q <= ring_mem[walk_q];
      rd_vbit_q <= ring_vld_q[walk_q];
    end
  end

  // Walk counter and recent-hit count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      walk_q    <= '0;
      rd_pend_q <= 1'b0;
      rcnt_q    <= '0;
      now_q     <= '0;
    end else begin
      state_q   <= state_d;
      rd_pend_q <= rd_en;
      if (is_snap) begin
        walk_q <= '0;
        rcnt_q <= '0;
        now_q  <= q_item_i.tick;
      end else begin
        if (rd_en) begin
          walk_q <= walk_q + 1'b1;
        end
        if (hit) begin
          rcnt_q <= rcnt_q + 1'b1;
        end
      end
    end
  end

  // Capture elapsed times at the snapshot, convert to seconds during the walk
  assign first_prod = 64'(first_num_q) * 64'(SecRecip);
  assign last_prod  = 64'(last_num_q) * 64'(SecRecip);

  always_ff @(posedge clk_i) begin
    if (is_snap) begin
      first_num_q <= have_first_q ? (first_q - start_q) : 32'd0;
      last_num_q  <= have_first_q ? (last_q - start_q) : 32'd0;
    end
    first_sec_q <= first_prod[SecShift +: 23];
    last_sec_q  <= last_prod[SecShift +: 23];
  end

  // Convert microsecond figures while the ring is walked
  idm_div u_div_thr (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(is_snap),
    .num_i  (thr_q),
    .den_i  (cpu_q),
    .done_o (div_done[0]),
    .quot_o (q_thr)
  );

  idm_div u_div_max (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(is_snap),
    .num_i  (max_q),
    .den_i  (cpu_q),
    .done_o (div_done[1]),
    .quot_o (q_max)
  );

  // Hold the result until the receiver takes it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_load) begin
      out_vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q.event_count       <= icnt_q;
      out_q.late_count        <= ocnt_q;
      out_q.threshold_us      <= q_thr;
      out_q.max_interval_us   <= q_max;
      out_q.first_late_sec    <= first_sec_q;
      out_q.last_late_sec     <= last_sec_q;
      out_q.recent_late_count <= 7'(rcnt_q);
      out_q.recent_capped     <= (rcnt_q >= RcntW'(RingDepth));
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  a_pop_idle_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> !q_pop_o)
    else $error("queue popped while a snapshot is in progress");

  a_no_write_during_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ring_we && rd_en))
    else $error("ring written during the snapshot walk");

  a_rcnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rcnt_q <= RcntW'(RingDepth))
    else $error("recent count exceeds ring depth");

  a_drain_to_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DRAIN) |=> (state_q == ST_FIN) && !rd_pend_q)
    else $error("walk did not finish after the last ring read");
`endif

endmodule

@@ src/interval_deadline_monitor.sv @@
// ----------------------------------------------------------------------------
// interval_deadline_monitor
// Event spacing monitor with overrun statistics and a ring of late ticks.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_data_i) carries event,
//   snapshot and clear transactions; unused command codes are dropped.
//   Only a snapshot produces a transaction on the output channel
//   (out_valid_o / out_stall_i / out_data_o).
//   Configuration writes (cfg_we_i, cfg_idx_i, cfg_wdata_i) take effect at
//   the clock edge; write them only while the block is idle.
//   An item is registered in the input stage and then held in the queue,
//   from which the back end pops it. Event and clear transactions update
//   the statistics as they are popped. A snapshot reads the 64 ring
//   entries through the single ring read port, one per cycle; the two
//   microsecond divisions and the seconds conversion run alongside the walk.
//   Events are taken one per cycle while no snapshot is in progress; a
//   snapshot holds the queue until its result enters the output register.
//   A held result blocks nothing until the next snapshot has walked the
//   ring; that one then waits, and the queue (four entries) and the input
//   stage fill before in_stall_o rises.
//   Reset clears statistics, ring valid bits and configuration (threshold 0,
//   divisor CyclesPerUsReset); no clearing pass is needed.
// ----------------------------------------------------------------------------
module interval_deadline_monitor
  import idm_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_data_t    in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_data_t   out_data_o
);

  q_push_t push;
  logic    full;
  logic    empty;
  logic    pop;
  q_item_t item;

  idm_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .in_data_i (in_data_i),
    .push_o    (push),
    .full_i    (full)
  );

  idm_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .full_o (full),
    .pop_i  (pop),
    .empty_o(empty),
    .item_o (item)
  );

  idm_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .q_empty_i  (empty),
    .q_item_i   (item),
    .q_pop_o    (pop),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

endmodule

@@ tb/interval_deadline_monitor_tb.sv @@
// ----------------------------------------------------------------------------
// interval_deadline_monitor_tb
// Self-checking bench for the interval deadline monitor. A directed script
// covers reset state, unused commands, stamp and tick wrap, the recent-window
// edges, a zero overrun tick and the register extremes. Randomized phases
// follow, each under its own threshold and divisor setting, built mostly from
// periodic event streams with jitter and overruns. A bench-side model of the
// statistics predicts untyped snapshots; channels idle and stall at random.
// ----------------------------------------------------------------------------
module interval_deadline_monitor_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import idm_pkg::*;

  localparam logic [1:0]  CmdUnused       = 2'd3;
  localparam int unsigned SettleCycles    = 150;
  localparam int unsigned CycleLimit      = 1_000_000;
  localparam int unsigned PhaseItems      = 180;
  localparam int unsigned RandomPhases    = 8;
  localparam int unsigned ShownMismatches = 10;

  typedef enum logic {ROW_TXN, ROW_REG} row_kind_e;

  typedef struct packed {
    row_kind_e   kind;
    logic [1:0]  cmd;
    logic [31:0] stamp;
    logic [31:0] tick;
    logic        reg_idx;
    logic [31:0] reg_val;
    logic        typed;
    out_data_t   want;
  } script_row_t;

  localparam out_data_t Blank       = '0;
  localparam out_data_t OneInterval = '{32'd1, 32'd0, 32'd0, 32'd0, 23'd0, 23'd0, 7'd0, 1'b0};

  // Directed script: typed results only where the value is obvious
  script_row_t script_rows [24] = '{
    // reset state, then an unused command that must leave it alone
    '{ROW_TXN, CmdSnap,   32'h0000_0000, 32'h0000_0000, RegThreshold, 32'h0, 1'b1, Blank},
    '{ROW_TXN, CmdUnused, 32'hFFFF_FFFF, 32'hFFFF_FFFF, RegThreshold, 32'h0, 1'b0, Blank},
    '{ROW_TXN, CmdSnap,   32'h0000_0000, 32'hFFFF_FFFF, RegThreshold, 32'h0, 1'b1, Blank},
    // first event only primes; second measures across the stamp wrap
    '{ROW_TXN, CmdEvent,  32'hFFFF_FFF0, 32'h0000_0001, RegThreshold, 32'h0, 1'b0, Blank},
    '{ROW_TXN, CmdEvent,  32'h0000_0010, 32'h0000_0002, RegThreshold, 32'h0, 1'b0, Blank},
    '{ROW_TXN, CmdSnap,   32'h0000_0000, 32'h0000_0003, RegThreshold, 32'h0, 1'b1, OneInterval},
    // smallest threshold and divisor
    '{ROW_REG, CmdEvent,  32'h0000_0000, 32'h0000_0000, RegThreshold, 32'h1, 1'b0, Blank},
    '{ROW_REG, CmdEvent,  32'h0000_0000, 32'h0000_0000, RegCyclesPerUs, 32'h1, 1'b0, Blank},
    '{ROW_TXN, CmdClear,  32'h0000_0000, 32'd1000,      RegThreshold, 32'h0, 1'b0, Blank},
    // overrun at tick zero: stored, never recent; first time before start
    '{ROW_TXN, CmdEvent,  32'h0000_0012, 32'h0000_0000, RegThreshold, 32'h0, 1'b0, Blank},
    '{ROW_TXN, CmdEvent,  32'h0000_0014, 32'd61000,     RegThreshold, 32'h0, 1'b0, Blank},
    '{ROW_TXN, CmdSnap,   32'h0000_0000, 32'd61000,     RegThreshold, 32'h0, 1'b0, Blank},
    // last tick inside the window, then just outside
    '{ROW_TXN, CmdSnap,   32'h0000_0000, 32'd120999,    RegThreshold, 32'h0, 1'b0, Blank},
    '{ROW_TXN, CmdSnap,   32'h0000_0000, 32'd121000,    RegThreshold, 32'h0, 1'b0, Blank},
    // all-ones interval, ring age across the tick wrap
    '{ROW_TXN, CmdEvent,  32'h0000_0013, 32'hFFFF_FFFF, RegThreshold, 32'h0, 1'b0, Blank},
    '{ROW_TXN, CmdSnap,   32'h0000_0000, 32'd59998,     RegThreshold, 32'h0, 1'b0, Blank},
    // largest threshold and a zero divisor
    '{ROW_REG, CmdEvent,  32'h0000_0000, 32'h0000_0000, RegThreshold, 32'hFFFF_FFFF, 1'b0, Blank},
    '{ROW_REG, CmdEvent,  32'h0000_0000, 32'h0000_0000, RegCyclesPerUs, 32'h0, 1'b0, Blank},
    '{ROW_TXN, CmdEvent,  32'h0000_0012, 32'h0000_0005, RegThreshold, 32'h0, 1'b0, Blank},
    '{ROW_TXN, CmdSnap,   32'h0000_0000, 32'h0000_0006, RegThreshold, 32'h0, 1'b0, Blank},
    // largest divisor, written with upper bits set
    '{ROW_REG, CmdEvent,  32'h0000_0000, 32'h0000_0000, RegCyclesPerUs, 32'hFFFF_FFFF, 1'b0,
      Blank},
    '{ROW_TXN, CmdSnap,   32'h0000_0000, 32'h0000_0007, RegThreshold, 32'h0, 1'b0, Blank},
    '{ROW_TXN, CmdClear,  32'h0000_0000, 32'hFFFF_FFFF, RegThreshold, 32'h0, 1'b0, Blank},
    '{ROW_TXN, CmdSnap,   32'h0000_0000, 32'h0000_0000, RegThreshold, 32'h0, 1'b0, Blank}
  };

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        cfg_we_i    = 1'b0;
  logic        cfg_idx_i   = RegThreshold;
  logic [31:0] cfg_wdata_i = '0;
  logic        in_valid_i  = 1'b0;
  logic        in_stall_o;
  in_data_t    in_data_i   = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  out_data_t   out_data_o;

  interval_deadline_monitor u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Bench copy of the monitor state and configuration
  logic [31:0] mon_threshold;
  logic [9:0]  mon_cyc_per_us;
  logic [31:0] mon_prev_stamp;
  bit          mon_primed;
  logic [31:0] mon_origin_tick;
  logic [31:0] mon_intervals;
  logic [31:0] mon_overruns;
  logic [31:0] mon_longest;
  bit          mon_seen_late;
  logic [31:0] mon_first_late;
  logic [31:0] mon_last_late;
  logic [31:0] mon_late_ticks [RingDepth];
  int unsigned mon_head;

  out_data_t   snaps_due [$];
  bit          steady;
  int unsigned cycle_count;
  int unsigned fail_count;
  int unsigned shown_count;
  int unsigned n_items;
  int unsigned n_events;
  int unsigned n_checked;
  int unsigned n_settings;

  // Drop all statistics and the ring; start counting time from now
  function automatic void mon_clear(input logic [31:0] now);
    mon_intervals   = '0;
    mon_overruns    = '0;
    mon_longest     = '0;
    mon_seen_late   = 1'b0;
    mon_first_late  = '0;
    mon_last_late   = '0;
    mon_head        = 0;
    mon_origin_tick = now;
    foreach (mon_late_ticks[i]) mon_late_ticks[i] = '0;
  endfunction

  // Expected snapshot for a query at tick now
  function automatic out_data_t mon_snapshot(input logic [31:0] now);
    out_data_t   s;
    logic [31:0] recent;
    logic [31:0] age;
    logic [31:0] secs;
    s = '0;
    recent = '0;
    foreach (mon_late_ticks[i]) begin
      age = now - mon_late_ticks[i];
      if (mon_late_ticks[i] != '0 && age < WindowMs) recent++;
    end
    s.event_count = mon_intervals;
    s.late_count  = mon_overruns;
    if (mon_cyc_per_us != '0) begin
      s.threshold_us    = mon_threshold / {22'd0, mon_cyc_per_us};
      s.max_interval_us = mon_longest / {22'd0, mon_cyc_per_us};
    end
    if (mon_seen_late) begin
      secs = (mon_first_late - mon_origin_tick) / {22'd0, MsPerSec};
      s.first_late_sec = secs[22:0];
      secs = (mon_last_late - mon_origin_tick) / {22'd0, MsPerSec};
      s.last_late_sec = secs[22:0];
    end
    s.recent_late_count = recent[6:0];
    s.recent_capped     = (recent >= RingDepth);
    return s;
  endfunction

  // Advance the bench state by one accepted transaction
  task automatic mon_apply(input in_data_t t, input bit typed, input out_data_t want);
    logic [31:0] gap;
    case (t.cmd)
      CmdEvent: begin
        if (mon_primed) begin
          gap = t.cycle_stamp - mon_prev_stamp;
          mon_intervals++;
          if (gap > mon_longest) mon_longest = gap;
          if (mon_threshold != '0 && gap > mon_threshold) begin
            mon_overruns++;
            if (!mon_seen_late) begin
              mon_seen_late  = 1'b1;
              mon_first_late = t.tick_ms;
            end
            mon_last_late = t.tick_ms;
            mon_late_ticks[mon_head] = t.tick_ms;
            mon_head = (mon_head + 1) % RingDepth;
          end
        end
        mon_primed     = 1'b1;
        mon_prev_stamp = t.cycle_stamp;
        n_events++;
      end
      CmdSnap: begin
        snaps_due.push_back(typed ? want : mon_snapshot(t.tick_ms));
      end
      CmdClear: begin
        mon_clear(t.tick_ms);
      end
      default: ; // unused code: dropped by the block
    endcase
  endtask

  // Offer one transaction after a random gap and wait for the handshake
  task automatic send_txn(input in_data_t t, input bit typed, input out_data_t want);
    while (!steady && $urandom_range(99) < 30) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= t;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    mon_apply(t, typed, want);
    if (t.cmd != CmdUnused) n_items++;
  endtask

  // Hold off input until every snapshot is back and the queue has drained
  task automatic settle();
    in_valid_i <= 1'b0;
    while (snaps_due.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input logic [31:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    if (idx == RegThreshold) begin
      mon_threshold = val;
    end else begin
      mon_cyc_per_us = val[9:0];
    end
    n_settings++;
  endtask

  // Compare a snapshot transaction with the oldest expectation
  task automatic check_result(input out_data_t got);
    out_data_t want;
    bit        bad;
    if (snaps_due.size() == 0) begin
      fail_count++;
      if (shown_count < ShownMismatches) begin
        shown_count++;
        $display("[%0t] unexpected snapshot result", $realtime);
      end
    end else begin
      want = snaps_due.pop_front();
      n_checked++;
      bad = (got.event_count != want.event_count) ||
            (got.late_count != want.late_count) ||
            (got.threshold_us != want.threshold_us) ||
            (got.max_interval_us != want.max_interval_us) ||
            (got.first_late_sec != want.first_late_sec) ||
            (got.last_late_sec != want.last_late_sec) ||
            (got.recent_late_count != want.recent_late_count) ||
            (got.recent_capped != want.recent_capped);
      if (bad) begin
        fail_count++;
        if (shown_count < ShownMismatches) begin
          shown_count++;
          $display("[%0t] snapshot %0d mismatch", $realtime, n_checked);
          $display("  exp ev=%0d late=%0d thr_us=%0d max_us=%0d first=%0d last=%0d rc=%0d cap=%0d",
                   want.event_count, want.late_count, want.threshold_us,
                   want.max_interval_us, want.first_late_sec, want.last_late_sec,
                   want.recent_late_count, want.recent_capped);
          $display("  got ev=%0d late=%0d thr_us=%0d max_us=%0d first=%0d last=%0d rc=%0d cap=%0d",
                   got.event_count, got.late_count, got.threshold_us,
                   got.max_interval_us, got.first_late_sec, got.last_late_sec,
                   got.recent_late_count, got.recent_capped);
        end
      end
    end
  endtask

  // Watch the result channel, stall it at random, guard the run length
  always @(posedge clk_i) begin
    cycle_count++;
    if (rst_ni && out_valid_o && !out_stall_i) check_result(out_data_o);
    out_stall_i <= !steady && ($urandom_range(99) < 30);
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Stimulus: directed script, then randomized phases
  initial begin
    in_data_t    t;
    int unsigned phase;
    int unsigned done;
    int unsigned nominal;
    int unsigned span;
    int unsigned r;
    int unsigned k;
    logic [31:0] thr;
    logic [31:0] cpu_word;
    logic [31:0] gen_stamp;
    logic [31:0] gen_tick;
    bit          calm;

    mon_threshold  = '0;
    mon_cyc_per_us = CyclesPerUsReset;
    mon_prev_stamp = '0;
    mon_primed     = 1'b0;
    mon_clear('0);
    steady = 1'b0;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Walk the directed script
    foreach (script_rows[i]) begin
      if (script_rows[i].kind == ROW_REG) begin
        settle();
        write_reg(script_rows[i].reg_idx, script_rows[i].reg_val);
      end else begin
        t.cmd         = script_rows[i].cmd;
        t.cycle_stamp = script_rows[i].stamp;
        t.tick_ms     = script_rows[i].tick;
        send_txn(t, script_rows[i].typed, script_rows[i].want);
      end
    end

    for (phase = 0; phase < RandomPhases; phase++) begin
      settle();
      nominal  = $urandom_range(8000, 64);
      cpu_word = $urandom;
      case (phase)
        0: begin
          thr = 32'd1;
          cpu_word[9:0] = 10'd1;
        end
        1: begin
          thr = nominal - nominal / 16 + $urandom_range(nominal / 8);
          cpu_word[9:0] = CyclesPerUsReset;
        end
        2: begin
          thr = '0;
          cpu_word[9:0] = 10'($urandom_range(1023, 1));
        end
        3: begin
          thr = nominal - nominal / 16 + $urandom_range(nominal / 8);
          cpu_word[9:0] = 10'h3FF;
        end
        4: begin
          thr = 32'hFFFF_FFFF;
          cpu_word[9:0] = 10'd0;
        end
        default: begin
          thr = ($urandom_range(3) == 0) ? $urandom
                                         : nominal - nominal / 16 + $urandom_range(nominal / 8);
          cpu_word[9:0] = 10'($urandom_range(1023));
        end
      endcase
      write_reg(RegThreshold, thr);
      write_reg(RegCyclesPerUs, cpu_word);

      // Phase 0 keeps the window intact so the ring can fill; phase 3 never idles
      calm      = (phase == 0);
      steady    = (phase == 3);
      gen_stamp = $urandom;
      gen_tick  = $urandom;
      done      = 0;
      while (done < PhaseItems) begin
        r = $urandom_range(99);
        if (r < 3) begin
          t.cmd         = 2'($urandom_range(3));
          t.cycle_stamp = $urandom;
          t.tick_ms     = $urandom;
        end else if (r < 5) begin
          t.cmd         = CmdUnused;
          t.cycle_stamp = $urandom;
          t.tick_ms     = $urandom;
        end else if (r < 13) begin
          k = $urandom_range(99);
          t.cmd         = CmdSnap;
          t.cycle_stamp = $urandom;
          t.tick_ms     = gen_tick + ((k < 10) ? $urandom_range(60010, 59990)
                                                : $urandom_range(1500));
        end else if (r < 14 && !calm) begin
          t.cmd         = CmdClear;
          t.cycle_stamp = $urandom;
          t.tick_ms     = gen_tick;
        end else begin
          // Periodic event with jitter, overruns, tiny gaps and wild stamps
          k = $urandom_range(99);
          if (k < 70) begin
            span = nominal - nominal / 8 + $urandom_range(nominal / 4);
          end else if (k < 90) begin
            span = nominal * $urandom_range(4, 2);
          end else if (k < 97) begin
            span = $urandom_range(3);
          end else begin
            span = $urandom;
          end
          gen_stamp = gen_stamp + span;
          k = $urandom_range(99);
          if (!calm && k < 2) begin
            gen_tick = gen_tick + $urandom_range(70000, 20000);
          end else begin
            gen_tick = gen_tick + $urandom_range(2);
          end
          t.cmd         = CmdEvent;
          t.cycle_stamp = gen_stamp;
          t.tick_ms     = (k == 99) ? 32'd0 : gen_tick;
        end
        send_txn(t, 1'b0, Blank);
        if (t.cmd != CmdUnused) done++;
      end
    end

    steady = 1'b0;
    settle();

    $display("Covered %0d transactions (%0d events), %0d snapshots checked, %0d register writes",
             n_items, n_events, n_checked, n_settings);
    $display("Mismatching or unexpected results: %0d, still expected: %0d",
             fail_count, snaps_due.size());
    if (fail_count == 0 && snaps_due.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
